[hdl/dam_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dam_pkg
// Shared types, constants and helper functions of the digit array multiplier.
// ----------------------------------------------------------------------------
package dam_pkg;

   localparam int DIGITS_DEF = 32;
   localparam int DIGIT_W    = 4;
   localparam int RADIX_W    = 5;
   localparam int CSR_DW     = 32;
   localparam int CSR_AW     = 3;
   localparam int MAX_DPROD  = 225;   // largest product of two 4-bit digits

   localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;
   localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;
   localparam logic [RADIX_W-1:0] RADIX_MAX   = 5'd16;

   // register index, taken from paddr[2]
   localparam logic REG_RADIX = 1'b0;

   typedef struct packed {
      logic [DIGIT_W-1:0] digit_a;
      logic [DIGIT_W-1:0] digit_b;
   } req_type;

   typedef struct packed {
      logic [DIGIT_W-1:0] product_digit;
      logic               last_digit;
   } rsp_type;

   typedef struct packed {
      logic load_wr;     // write the accepted digit pair
      logic clear_acc;   // zero the column accumulator
      logic rd_en;       // read one digit pair for a partial product
      logic div_clear;   // zero the remainder before a division
      logic div_step;    // one restoring division step
   } cmd_type;

   // column sum plus incoming carry never exceeds twice the column bound
   function automatic int acc_width(input int digits);
      return $clog2(2 * digits * MAX_DPROD + 1);
   endfunction

   function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] r);
      logic [RADIX_W-1:0] res;
      res = r;
      if (r < RADIX_MIN) begin
         res = RADIX_MIN;
      end else if (r > RADIX_MAX) begin
         res = RADIX_MAX;
      end
      return res;
   endfunction

endpackage
`default_nettype wire

[hdl/dam_datapath.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dam_datapath
// Operand memories, digit multiply-accumulate pipe and bit-serial divider
// that splits each column sum into a product digit and a carry.
// ----------------------------------------------------------------------------
module dam_datapath #(
   parameter int DIGITS = dam_pkg::DIGITS_DEF,
   localparam int IDX_W = $clog2(DIGITS)
) (
   input  wire                              clock,
   input  wire                              reset,
   input  dam_pkg::cmd_type                 cmd,
   input  wire  [IDX_W-1:0]                 load_addr,
   input  wire  [IDX_W-1:0]                 rd_addr_a,
   input  wire  [IDX_W-1:0]                 rd_addr_b,
   input  dam_pkg::req_type                 req_data,
   input  wire  [dam_pkg::RADIX_W-1:0]      radix,
   output logic                             pipe_busy,
   output logic [dam_pkg::DIGIT_W-1:0]      digit
);
   import dam_pkg::*;

   localparam int ACC_W  = acc_width(DIGITS);
   localparam int PROD_W = 2 * DIGIT_W;

   logic [DIGIT_W-1:0] first_operand_ff  [DIGITS];
   logic [DIGIT_W-1:0] second_operand_ff [DIGITS];

   logic [DIGIT_W-1:0] rd_a_ff, rd_b_ff;
   logic [PROD_W-1:0]  prod_ff;
   logic               rd_vld_ff, rd_vld_in;
   logic               prod_vld_ff, prod_vld_in;
   logic [ACC_W-1:0]   acc_ff, acc_in;
   logic [DIGIT_W-1:0] rem_ff, rem_in;

   logic [RADIX_W-1:0] shifted;
   logic [RADIX_W-1:0] diff;
   logic               qbit;

   // operand memories: one write port, one registered read port each
   always_ff @(posedge clock) begin
      if (cmd.load_wr) begin
         first_operand_ff[load_addr]  <= req_data.digit_a;
         second_operand_ff[load_addr] <= req_data.digit_b;
      end
      if (cmd.rd_en) begin
         rd_a_ff <= first_operand_ff[rd_addr_a];
         rd_b_ff <= second_operand_ff[rd_addr_b];
      end
   end

   always_comb begin
      rd_vld_in   = cmd.rd_en;
      prod_vld_in = rd_vld_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff   <= 1'b0;
         prod_vld_ff <= 1'b0;
      end else begin
         rd_vld_ff   <= rd_vld_in;
         prod_vld_ff <= prod_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= PROD_W'(rd_a_ff) * PROD_W'(rd_b_ff);
   end

   // restoring division: remainder takes the dividend's top bit, the
   // quotient bit shifts into the accumulator from below
   always_comb begin
      shifted = {rem_ff, acc_ff[ACC_W-1]};
      diff    = shifted - radix;
      qbit    = (shifted >= radix);
   end

   always_comb begin
      acc_in = acc_ff;
      rem_in = rem_ff;
      if (cmd.clear_acc) begin
         acc_in = '0;
      end else if (cmd.div_step) begin
         acc_in = {acc_ff[ACC_W-2:0], qbit};
         rem_in = qbit ? diff[DIGIT_W-1:0] : shifted[DIGIT_W-1:0];
      end else if (prod_vld_ff) begin
         acc_in = acc_ff + ACC_W'(prod_ff);
      end
      if (cmd.div_clear) begin
         rem_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      rem_ff <= rem_in;
   end

   assign pipe_busy = rd_vld_ff | prod_vld_ff;
   assign digit     = rem_ff;

endmodule
`default_nettype wire

[hdl/dam_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dam_ctrl
// Sequencer: counts loaded digit pairs, walks the product columns, issues
// the partial products of each column, runs the divider and emits digits.
// ----------------------------------------------------------------------------
module dam_ctrl #(
   parameter int DIGITS = dam_pkg::DIGITS_DEF,
   localparam int IDX_W = $clog2(DIGITS)
) (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 start,
   input  wire                 pipe_busy,
   output logic                busy,
   output logic                rsp_strobe,
   output logic                last_digit,
   output dam_pkg::cmd_type    cmd,
   output logic [IDX_W-1:0]    load_addr,
   output logic [IDX_W-1:0]    rd_addr_a,
   output logic [IDX_W-1:0]    rd_addr_b
);
   import dam_pkg::*;

   localparam int ACC_W  = acc_width(DIGITS);
   localparam int STEP_W = $clog2(ACC_W);
   localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(DIGITS - 1);
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(ACC_W - 1);
   localparam logic [IDX_W-1:0]  IDX_ONE   = IDX_W'(1);
   localparam logic [STEP_W-1:0] STEP_ONE  = STEP_W'(1);

   typedef enum logic [2:0] {
      S_LOAD,
      S_MAC,
      S_DRAIN,
      S_DIV,
      S_EMIT
   } state_type;

   state_type         state_ff, state_in;
   logic [IDX_W-1:0]  load_cnt_ff, load_cnt_in;
   logic [IDX_W-1:0]  col_ff, col_in;
   logic [IDX_W-1:0]  term_ff, term_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              busy_ff, busy_in;
   logic              strobe_ff, strobe_in;
   logic              last_ff, last_in;
   logic              accept;

   assign accept = start & ~busy_ff;

   always_comb begin
      state_in    = state_ff;
      load_cnt_in = load_cnt_ff;
      col_in      = col_ff;
      term_in     = term_ff;
      step_in     = step_ff;
      busy_in     = busy_ff;
      strobe_in   = 1'b0;
      last_in     = last_ff;
      cmd         = '0;
      case (state_ff)
         S_LOAD: begin
            cmd.load_wr = accept;
            if (accept) begin
               if (load_cnt_ff == LAST_IDX) begin
                  load_cnt_in   = '0;
                  cmd.clear_acc = 1'b1;
                  col_in        = '0;
                  term_in       = '0;
                  busy_in       = 1'b1;
                  state_in      = S_MAC;
               end else begin
                  load_cnt_in = load_cnt_ff + IDX_ONE;
               end
            end
         end
         S_MAC: begin
            cmd.rd_en = 1'b1;
            if (term_ff == col_ff) begin
               state_in = S_DRAIN;
            end else begin
               term_in = term_ff + IDX_ONE;
            end
         end
         S_DRAIN: begin
            // hold until the last partial product is in the accumulator
            if (!pipe_busy) begin
               cmd.div_clear = 1'b1;
               step_in       = '0;
               state_in      = S_DIV;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            step_in      = step_ff + STEP_ONE;
            if (step_ff == LAST_STEP) begin
               strobe_in = 1'b1;
               last_in   = (col_ff == LAST_IDX);
               state_in  = S_EMIT;
            end
         end
         S_EMIT: begin
            // quotient left in the accumulator is the next column's carry
            if (col_ff == LAST_IDX) begin
               busy_in  = 1'b0;
               state_in = S_LOAD;
            end else begin
               col_in   = col_ff + IDX_ONE;
               term_in  = '0;
               state_in = S_MAC;
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_LOAD;
         load_cnt_ff <= '0;
         col_ff      <= '0;
         term_ff     <= '0;
         step_ff     <= '0;
         busy_ff     <= 1'b0;
         strobe_ff   <= 1'b0;
         last_ff     <= 1'b0;
      end else begin
         state_ff    <= state_in;
         load_cnt_ff <= load_cnt_in;
         col_ff      <= col_in;
         term_ff     <= term_in;
         step_ff     <= step_in;
         busy_ff     <= busy_in;
         strobe_ff   <= strobe_in;
         last_ff     <= last_in;
      end
   end

   assign busy       = busy_ff;
   assign rsp_strobe = strobe_ff;
   assign last_digit = last_ff;
   assign load_addr  = load_cnt_ff;
   assign rd_addr_a  = term_ff;
   assign rd_addr_b  = col_ff - term_ff;

endmodule
`default_nettype wire

[hdl/digit_array_multiplier.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// digit_array_multiplier
// Schoolbook multiplier of two DIGITS-digit numbers in a programmable radix.
// ----------------------------------------------------------------------------
// Load the operands one digit pair per item, least significant first; busy
// stays low while loading, so a pair can be taken every cycle. The item that
// completes the operands raises busy. The product is then formed column by
// column: column k takes k+1 digit multiply-accumulate steps (one partial
// product per cycle, limited by the single read port of each operand
// memory), a drain of the read and multiply registers, a bit-serial division
// of the ACC_W-bit column sum by the radix (ACC_W = clog2(450*DIGITS+1), 14
// for DIGITS=32) and an emit state. Product digits come out least significant
// first, each on rsp_strobe for one cycle; the receiver must take each one as
// it comes. Only the low DIGITS digits are given, the last one with last_digit
// set. The radix register reads back as written but is used clamped to 2..16,
// and must not be written while busy is high.
// ----------------------------------------------------------------------------
module digit_array_multiplier #(
   parameter int DIGITS = dam_pkg::DIGITS_DEF
) (
   input  wire                           clock,
   input  wire                           reset,
   // configuration
   input  wire                           psel,
   input  wire                           penable,
   input  wire                           pwrite,
   input  wire  [dam_pkg::CSR_AW-1:0]    paddr,
   input  wire  [dam_pkg::CSR_DW-1:0]    pwdata,
   output logic [dam_pkg::CSR_DW-1:0]    prdata,
   output logic                          pready,
   // operand digits
   input  wire                           start,
   output logic                          busy,
   input  dam_pkg::req_type              req_data,
   // product digits
   output logic                          rsp_strobe,
   output dam_pkg::rsp_type              rsp_data
);
   import dam_pkg::*;

   localparam int IDX_W = $clog2(DIGITS);

   logic [RADIX_W-1:0] radix_ff, radix_in;
   logic [RADIX_W-1:0] radix_eff;
   logic               csr_write;
   logic               reg_sel;

   cmd_type            cmd;
   logic [IDX_W-1:0]   load_addr;
   logic [IDX_W-1:0]   rd_addr_a;
   logic [IDX_W-1:0]   rd_addr_b;
   logic               pipe_busy;
   logic [DIGIT_W-1:0] digit;
   logic               last_digit;

   assign reg_sel   = paddr[2];
   assign csr_write = psel & penable & pwrite & pready;

   always_comb begin
      radix_in = radix_ff;
      if (csr_write && reg_sel == REG_RADIX) begin
         radix_in = pwdata[RADIX_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff <= RADIX_RESET;
      end else begin
         radix_ff <= radix_in;
      end
   end

   assign prdata    = (reg_sel == REG_RADIX) ? CSR_DW'(radix_ff) : '0;
   assign pready    = 1'b1;
   assign radix_eff = clamp_radix(radix_ff);

   dam_ctrl #(
      .DIGITS (DIGITS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .pipe_busy  (pipe_busy),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .last_digit (last_digit),
      .cmd        (cmd),
      .load_addr  (load_addr),
      .rd_addr_a  (rd_addr_a),
      .rd_addr_b  (rd_addr_b)
   );

   dam_datapath #(
      .DIGITS (DIGITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .load_addr (load_addr),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .req_data  (req_data),
      .radix     (radix_eff),
      .pipe_busy (pipe_busy),
      .digit     (digit)
   );

   assign rsp_data.product_digit = digit;
   assign rsp_data.last_digit    = last_digit;

endmodule
`default_nettype wire

[hdl/dam_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dam_checker
// Port-level checks of the digit array multiplier, bound to the top level.
// ----------------------------------------------------------------------------
module dam_checker (
   input wire              clock,
   input wire              reset,
   input wire              start,
   input wire              busy,
   input wire              rsp_strobe,
   input dam_pkg::rsp_type rsp_data
);
   import dam_pkg::*;

   // digits only come out during an operation
   a_strobe_in_op: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> busy)
      else $error("product digit outside an operation");

   // the divider separates consecutive digits
   a_strobe_spaced: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("product digits back to back");

   // the final digit ends the operation
   a_last_ends_op: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.last_digit) |=> !busy)
      else $error("busy held after final digit");

   // an operation starts only from an accepted item
   a_busy_from_item: assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> $past(start))
      else $error("busy rose without an item");

endmodule

bind digit_array_multiplier dam_checker u_dam_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_strobe (rsp_strobe),
   .rsp_data   (rsp_data)
);
`default_nettype wire

[verif/dam_product_checker.sv]
// ----------------------------------------------------------------------------
// dam_product_checker
// Watches the register port and both digit channels of the multiplier. It
// keeps its own copy of the radix and the operand digits, works out the
// product digits when an operand load completes, and compares every digit
// that comes out against the oldest one still expected.
// ----------------------------------------------------------------------------
module dam_product_checker #(
   parameter int DIGITS = dam_pkg::DIGITS_DEF
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          psel,
   input  wire                          penable,
   input  wire                          pwrite,
   input  wire  [dam_pkg::CSR_AW-1:0]   paddr,
   input  wire  [dam_pkg::CSR_DW-1:0]   pwdata,
   input  wire                          pready,
   input  wire                          start,
   input  wire                          busy,
   input  dam_pkg::req_type             req_data,
   input  wire                          rsp_strobe,
   input  dam_pkg::rsp_type             rsp_data,
   output int                           mismatches,
   output int                           outstanding
);
   import dam_pkg::*;

   logic [RADIX_W-1:0] radix_reg;
   logic [DIGIT_W-1:0] operand_a [DIGITS];
   logic [DIGIT_W-1:0] operand_b [DIGITS];
   int                 load_pos;
   int                 error_total;
   rsp_type            expected_digits [$];

   initial begin
      error_total = 0;
      load_pos    = 0;
      radix_reg   = RADIX_RESET;
      mismatches  = 0;
      outstanding = 0;
   end

   // Schoolbook product modulo base**DIGITS: one row per digit of b,
   // normalized after each row, carries past the top position dropped.
   task automatic queue_product_digits();
      int unsigned base;
      int unsigned carry;
      int unsigned v;
      int unsigned row [DIGITS];
      int unsigned acc [DIGITS];
      rsp_type     digit_out;
      base = radix_reg;
      if (radix_reg < RADIX_MIN) begin
         base = RADIX_MIN;
      end else if (radix_reg > RADIX_MAX) begin
         base = RADIX_MAX;
      end
      for (int i = 0; i < DIGITS; i++) begin
         acc[i] = 0;
      end
      for (int j = 0; j < DIGITS; j++) begin
         carry = 0;
         for (int i = 0; i < DIGITS; i++) begin
            v      = operand_a[i] * operand_b[j] + carry;
            row[i] = v % base;
            carry  = v / base;
         end
         for (int i = 0; i + j < DIGITS; i++) begin
            acc[i + j] += row[i];
         end
         carry = 0;
         for (int i = 0; i < DIGITS; i++) begin
            v      = acc[i] + carry;
            acc[i] = v % base;
            carry  = v / base;
         end
      end
      for (int i = 0; i < DIGITS; i++) begin
         digit_out.product_digit = acc[i][DIGIT_W-1:0];
         digit_out.last_digit    = (i == DIGITS - 1);
         expected_digits.push_back(digit_out);
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         radix_reg = RADIX_RESET;
         load_pos  = 0;
         expected_digits.delete();
      end else begin
         if (rsp_strobe === 1'b1) begin
            if (expected_digits.size() == 0) begin
               $error("product_digit: expected none, got %0d", rsp_data.product_digit);
               error_total++;
            end else begin
               want = expected_digits.pop_front();
               if (rsp_data.product_digit !== want.product_digit) begin
                  $error("product_digit: expected %0d, got %0d",
                         want.product_digit, rsp_data.product_digit);
                  error_total++;
               end
               if (rsp_data.last_digit !== want.last_digit) begin
                  $error("last_digit: expected %0d, got %0d",
                         want.last_digit, rsp_data.last_digit);
                  error_total++;
               end
            end
         end
         if (psel && penable && pwrite && pready && paddr[CSR_AW-1:2] == REG_RADIX) begin
            radix_reg = pwdata[RADIX_W-1:0];
         end
         if (start === 1'b1 && busy === 1'b0) begin
            operand_a[load_pos] = req_data.digit_a;
            operand_b[load_pos] = req_data.digit_b;
            load_pos++;
            if (load_pos == DIGITS) begin
               load_pos = 0;
               queue_product_digits();
            end
         end
      end
      mismatches  <= error_total;
      outstanding <= expected_digits.size();
   end

endmodule

[verif/digit_array_multiplier_test.sv]
// ----------------------------------------------------------------------------
// digit_array_multiplier_test
// Drives operand digit pairs and radix writes into the multiplier: a directed
// set of operations covering digit extremes, radix clamping, digits at or
// above the radix, overflow, an ignored register and a radix change during a
// load, then random operations with random idle bursts. The checker beside
// the block predicts and compares every product digit.
// ----------------------------------------------------------------------------
module digit_array_multiplier_test;
   import dam_pkg::*;

   localparam int DIGITS      = DIGITS_DEF;
   localparam int CYCLE_LIMIT = 500000;
   localparam int DRAIN_WAIT  = 40;
   localparam int RANDOM_OPS  = 5;
   localparam int CALM_OPS    = 3;
   localparam int NO_SPLIT    = -1;

   localparam logic [CSR_AW-1:0] ADDR_RADIX = {REG_RADIX, 2'b00};
   localparam logic [CSR_AW-1:0] ADDR_SPARE = {~REG_RADIX, 2'b00};

   typedef enum int {
      DIG_ZERO,    // all zeros
      DIG_TOP,     // radix - 1 everywhere
      DIG_MAX,     // 15 everywhere, whatever the radix
      DIG_BELOW,   // random below the radix
      DIG_FULL     // random over the whole field
   } digit_mode_type;

   logic              clock;
   logic              reset;
   logic              psel;
   logic              penable;
   logic              pwrite;
   logic [CSR_AW-1:0] paddr;
   logic [CSR_DW-1:0] pwdata;
   logic [CSR_DW-1:0] prdata;
   logic              pready;
   logic              start;
   logic              busy;
   req_type           req_data;
   logic              rsp_strobe;
   rsp_type           rsp_data;

   int                mismatches;
   int                outstanding;
   int                cycle_count;
   logic [RADIX_W-1:0] cur_radix;

   digit_array_multiplier #(.DIGITS(DIGITS)) u_top (
      .clock      (clock),
      .reset      (reset),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   dam_product_checker #(.DIGITS(DIGITS)) u_check (
      .clock       (clock),
      .reset       (reset),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .pready      (pready),
      .start       (start),
      .busy        (busy),
      .req_data    (req_data),
      .rsp_strobe  (rsp_strobe),
      .rsp_data    (rsp_data),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   function automatic logic [DIGIT_W-1:0] pick_digit(input digit_mode_type mode);
      int unsigned base;
      base = (cur_radix < RADIX_MIN) ? RADIX_MIN :
             (cur_radix > RADIX_MAX) ? RADIX_MAX : cur_radix;
      case (mode)
         DIG_ZERO:  return '0;
         DIG_TOP:   return DIGIT_W'(base - 1);
         DIG_MAX:   return '1;
         DIG_BELOW: return DIGIT_W'($urandom_range(0, base - 1));
         default:   return DIGIT_W'($urandom_range(0, 15));
      endcase
   endfunction

   function automatic digit_mode_type random_mode();
      case ($urandom_range(0, 9))
         0:       return DIG_ZERO;
         1:       return DIG_TOP;
         2:       return DIG_MAX;
         3, 4, 5: return DIG_BELOW;
         default: return DIG_FULL;
      endcase
   endfunction

   // Register write, setup phase then access phase; start must already be low.
   task automatic csr_write(input logic [CSR_AW-1:0] addr, input logic [CSR_DW-1:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      if (addr[CSR_AW-1:2] == REG_RADIX) begin
         cur_radix = data[RADIX_W-1:0];
      end
   endtask

   task automatic send_pair(input logic [DIGIT_W-1:0] a, input logic [DIGIT_W-1:0] b,
                            input bit allow_idle);
      int gap;
      if (allow_idle && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 10);
         start    <= 1'b0;
         req_data <= req_type'($urandom);
         repeat (gap) @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= req_type'{digit_a: a, digit_b: b};
      do @(posedge clock); while (busy);
   endtask

   // Drop start, let every product digit arrive, then give the block time to
   // fall idle before anything touches the radix.
   task automatic wait_idle();
      start <= 1'b0;
      do @(posedge clock); while (outstanding != 0 || busy);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic run_operation(input digit_mode_type mode_a, input digit_mode_type mode_b,
                                input bit allow_idle, input int split_at,
                                input logic [RADIX_W-1:0] split_radix);
      for (int i = 0; i < DIGITS; i++) begin
         if (i == split_at) begin
            start <= 1'b0;
            csr_write(ADDR_RADIX, CSR_DW'(split_radix));
         end
         send_pair(pick_digit(mode_a), pick_digit(mode_b), allow_idle);
      end
      wait_idle();
   endtask

   initial begin
      logic [RADIX_W-1:0] new_radix;
      bit                 calm;
      psel      <= 1'b0;
      penable   <= 1'b0;
      pwrite    <= 1'b0;
      paddr     <= '0;
      pwdata    <= '0;
      start     <= 1'b0;
      req_data  <= '0;
      reset     <= 1'b1;
      cur_radix = RADIX_RESET;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);

      // directed operations
      run_operation(DIG_TOP, DIG_TOP, 1'b1, NO_SPLIT, '0);
      run_operation(DIG_ZERO, DIG_FULL, 1'b1, NO_SPLIT, '0);
      csr_write(ADDR_RADIX, CSR_DW'(RADIX_MAX));
      run_operation(DIG_TOP, DIG_TOP, 1'b1, NO_SPLIT, '0);
      csr_write(ADDR_RADIX, CSR_DW'(RADIX_MIN));
      run_operation(DIG_TOP, DIG_MAX, 1'b1, NO_SPLIT, '0);
      csr_write(ADDR_RADIX, '0);
      run_operation(DIG_FULL, DIG_FULL, 1'b1, NO_SPLIT, '0);
      csr_write(ADDR_RADIX, CSR_DW'(31));
      run_operation(DIG_FULL, DIG_MAX, 1'b1, NO_SPLIT, '0);
      csr_write(ADDR_RADIX, CSR_DW'(17));
      run_operation(DIG_BELOW, DIG_BELOW, 1'b1, NO_SPLIT, '0);
      // the spare register must leave the radix alone
      csr_write(ADDR_SPARE, CSR_DW'(3));
      run_operation(DIG_FULL, DIG_FULL, 1'b1, NO_SPLIT, '0);
      // radix change partway through a load
      csr_write(ADDR_RADIX, CSR_DW'(3));
      run_operation(DIG_BELOW, DIG_FULL, 1'b1, 12, RADIX_W'(7));

      // random operations, no idling in the last few
      for (int op = 0; op < RANDOM_OPS; op++) begin
         calm = (op >= RANDOM_OPS - CALM_OPS);
         if ($urandom_range(0, 1) == 0) begin
            new_radix = ($urandom_range(0, 7) == 0) ? RADIX_W'($urandom_range(0, 31))
                                                    : RADIX_W'($urandom_range(2, 16));
            csr_write(($urandom_range(0, 7) == 0) ? ADDR_SPARE : ADDR_RADIX,
                      {$urandom} & ~CSR_DW'({RADIX_W{1'b1}}) | CSR_DW'(new_radix));
         end
         new_radix = RADIX_W'($urandom_range(2, 16));
         run_operation(random_mode(), random_mode(), !calm,
                       ($urandom_range(0, 4) == 0) ? $urandom_range(1, DIGITS - 1) : NO_SPLIT,
                       new_radix);
      end

      if (mismatches == 0 && outstanding == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

[sim.f]
hdl/dam_pkg.sv
hdl/dam_datapath.sv
hdl/dam_ctrl.sv
hdl/digit_array_multiplier.sv
hdl/dam_checker.sv
verif/dam_product_checker.sv
verif/digit_array_multiplier_test.sv
